/* hdl/dlts_pkg.sv */
// Package: shared types and constants for the delta-list task scheduler.
package dlts_pkg;

	localparam int MaxTasksDefault = 16;
	localparam logic [31:0] ReservedId = 32'd0;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_ADD      = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_READY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TICK_RD,
		S_TICK_WR,
		S_ADD_RD,
		S_ADD_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_ADD_FILL,
		S_POP_RD,
		S_POP_CHK,
		S_POP_SHIFT_RD,
		S_POP_SHIFT_WR,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [7:0]  handle;
		logic [31:0] delta;
		logic [31:0] period;
		logic [31:0] id;
		logic        ready;
	} entry_t;

endpackage

/* hdl/delta_list_task_scheduler_core.sv */
// Top level: delta-list timer queue with one table memory and a sequencer.
// A tick reads and rewrites the head entry. An add walks the list, shifts the entries
// behind the insert point and writes the new one; an add to a full table reports full
// at once. A dispatch shifts the remaining entries up and re-adds a periodic task with
// a walk of its own. One word is taken at a time: in_ready stays low from accept until
// the result has been taken.
module delta_list_task_scheduler_core #(
	parameter int MAX_TASKS = dlts_pkg::MaxTasksDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  task_handle,
	input  logic [31:0] delay,
	input  logic [31:0] period,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  task_handle_out,
	output logic [31:0] task_id
);
	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	// Entry table: valid entries always fill slots 0 .. count_q-1, so
	// a fill count stands in for the valid bits.
	// Reset: arst_n clears the fill count, id counter, sequencer and output valid.
	dlts_pkg::entry_t mem [MAX_TASKS];
	dlts_pkg::entry_t rd_q;
	logic             mem_we;
	logic [AW-1:0]    mem_wa, mem_ra;
	dlts_pkg::entry_t mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	dlts_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [31:0]   idc_q;
	logic [AW-1:0] idx_q;       // walk / shift pointer
	logic [32:0]   sum_q;       // running delta sum
	logic [7:0]    h_q;
	logic [31:0]   d_q, p_q;
	logic          readd_q;     // add walk is a periodic re-add
	logic [AW-1:0] ins_q;       // insert position
	logic [31:0]   split_q;     // new delta of the entry behind the insert
	logic          split_q_v;
	logic [1:0]    st_q;
	logic [7:0]    oh_q;
	logic [31:0]   oid_q;
	logic          ov_q;

	logic [32:0] sum_nx;
	logic [31:0] id_nx;
	assign sum_nx = sum_q + {1'b0, rd_q.delta};
	assign id_nx  = (idc_q + 32'd1 == dlts_pkg::ReservedId) ? idc_q + 32'd2 : idc_q + 32'd1;

	assign in_ready        = (state_q == dlts_pkg::S_IDLE) && !ov_q;
	assign out_valid       = ov_q;
	assign status          = st_q;
	assign task_handle_out = oh_q;
	assign task_id         = oid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dlts_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					unique case (dlts_pkg::op_t'(operation))
						dlts_pkg::OP_TICK:     state_d = dlts_pkg::S_TICK_RD;
						dlts_pkg::OP_ADD:      state_d = dlts_pkg::S_ADD_RD;
						dlts_pkg::OP_DISPATCH: state_d = dlts_pkg::S_POP_RD;
						default:               state_d = dlts_pkg::S_OUT;
					endcase
				end
			end
			dlts_pkg::S_TICK_RD: state_d = dlts_pkg::S_TICK_WR;
			dlts_pkg::S_TICK_WR: state_d = dlts_pkg::S_OUT;
			dlts_pkg::S_ADD_RD: begin
				if (count_q == CW'(MAX_TASKS))
					state_d = readd_q ? dlts_pkg::S_IDLE : dlts_pkg::S_OUT;
				else if (CW'(idx_q) == count_q)
					state_d = dlts_pkg::S_ADD_FILL;
				else
					state_d = dlts_pkg::S_ADD_CHK;
			end
			dlts_pkg::S_ADD_CHK: begin
				if (sum_nx > {1'b0, d_q})
					state_d = (count_q[AW-1:0] == idx_q) ?
						dlts_pkg::S_ADD_FILL : dlts_pkg::S_SHIFT_RD;
				else
					state_d = dlts_pkg::S_ADD_RD;
			end
			dlts_pkg::S_SHIFT_RD: state_d = dlts_pkg::S_SHIFT_WR;
			dlts_pkg::S_SHIFT_WR:
				state_d = (idx_q == ins_q + AW'(1)) ?
					dlts_pkg::S_ADD_FILL : dlts_pkg::S_SHIFT_RD;
			dlts_pkg::S_ADD_FILL: state_d = readd_q ? dlts_pkg::S_IDLE : dlts_pkg::S_OUT;
			dlts_pkg::S_POP_RD: state_d = dlts_pkg::S_POP_CHK;
			dlts_pkg::S_POP_CHK: begin
				if (count_q == '0 || !rd_q.ready)
					state_d = dlts_pkg::S_OUT;
				else if (count_q == CW'(1))
					state_d = (rd_q.period == '0) ? dlts_pkg::S_OUT : dlts_pkg::S_ADD_RD;
				else
					state_d = dlts_pkg::S_POP_SHIFT_RD;
			end
			dlts_pkg::S_POP_SHIFT_RD: state_d = dlts_pkg::S_POP_SHIFT_WR;
			dlts_pkg::S_POP_SHIFT_WR: begin
				if (CW'(idx_q) + CW'(1) == count_q)
					state_d = (p_q == '0) ? dlts_pkg::S_OUT : dlts_pkg::S_ADD_RD;
				else
					state_d = dlts_pkg::S_POP_SHIFT_RD;
			end
			dlts_pkg::S_OUT: state_d = dlts_pkg::S_IDLE;
			default: state_d = dlts_pkg::S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_ra = idx_q;
		mem_wd = rd_q;
		unique case (state_q)
			dlts_pkg::S_IDLE:   mem_ra = '0;
			dlts_pkg::S_TICK_WR: begin
				mem_wa = '0;
				mem_we = (count_q != '0) && !rd_q.ready;
				if (rd_q.delta != '0) mem_wd.delta = rd_q.delta - 32'd1;
				mem_wd.ready = (mem_wd.delta == '0);
			end
			dlts_pkg::S_SHIFT_RD: mem_ra = idx_q - AW'(1);
			dlts_pkg::S_SHIFT_WR: begin
				mem_we = 1'b1;
				if (idx_q == ins_q + AW'(1) && split_q_v) mem_wd.delta = split_q;
			end
			dlts_pkg::S_ADD_FILL: begin
				mem_we = 1'b1;
				mem_wa = ins_q;
				mem_wd.handle = h_q;
				mem_wd.delta  = d_q - sum_q[31:0];
				mem_wd.period = p_q;
				mem_wd.id     = id_nx;
				mem_wd.ready  = (mem_wd.delta == '0);
			end
			dlts_pkg::S_POP_RD: mem_ra = '0;
			dlts_pkg::S_POP_CHK: mem_ra = AW'(1);
			dlts_pkg::S_POP_SHIFT_RD: mem_ra = idx_q + AW'(1);
			dlts_pkg::S_POP_SHIFT_WR: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlts_pkg::S_IDLE;
			count_q <= '0;
			idc_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			// a periodic re-add presents the dispatch result when its walk ends
			if (state_q == dlts_pkg::S_OUT ||
			    (readd_q && state_q != dlts_pkg::S_IDLE && state_d == dlts_pkg::S_IDLE))
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			if (state_q == dlts_pkg::S_ADD_FILL) begin
				count_q <= count_q + CW'(1);
				idc_q   <= id_nx;
			end
			if (state_q == dlts_pkg::S_POP_CHK && count_q != '0 && rd_q.ready)
				count_q <= count_q - CW'(1);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			dlts_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					h_q <= task_handle; d_q <= delay; p_q <= period;
					idx_q <= '0; sum_q <= '0; readd_q <= 1'b0; split_q_v <= 1'b0;
					st_q <= dlts_pkg::ST_DONE; oh_q <= '0; oid_q <= '0;
				end
			end
			dlts_pkg::S_ADD_RD: begin
				ins_q <= idx_q;
				if (count_q == CW'(MAX_TASKS) && !readd_q) st_q <= dlts_pkg::ST_FULL;
			end
			dlts_pkg::S_ADD_CHK: begin
				if (sum_nx > {1'b0, d_q}) begin
					// split the following delta, then shift from the tail
					split_q   <= 32'(sum_nx - {1'b0, d_q});
					split_q_v <= 1'b1;
					idx_q     <= count_q[AW-1:0];
				end else begin
					sum_q <= sum_nx;
					idx_q <= idx_q + AW'(1);
					ins_q <= idx_q + AW'(1);
				end
			end
			dlts_pkg::S_SHIFT_WR: idx_q <= idx_q - AW'(1);
			dlts_pkg::S_ADD_FILL: if (!readd_q) oid_q <= id_nx;
			dlts_pkg::S_POP_CHK: begin
				if (count_q == '0 || !rd_q.ready) st_q <= dlts_pkg::ST_NO_READY;
				else begin
					oh_q <= rd_q.handle; oid_q <= rd_q.id;
					h_q <= rd_q.handle; d_q <= rd_q.period; p_q <= rd_q.period;
					readd_q <= 1'b1;
				end
			end
			dlts_pkg::S_POP_SHIFT_WR: begin
				// a re-add walk starts from slot 0
				if (state_d == dlts_pkg::S_ADD_RD) begin
					idx_q <= '0; sum_q <= '0;
				end else
					idx_q <= idx_q + AW'(1);
			end
			default: ;
		endcase
	end

endmodule
